[hdl/pq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pq_pkg;

	localparam int CMD_W   = 2;
	localparam int SLOT_W  = 5;
	localparam int ID_IN_W = 16;

	localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_STATUS  = 2'd3;

	// Command queue between the front and the back.
	localparam int         CQ_DEPTH = 2;
	localparam logic [1:0] CQ_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_APPEND,
		OP_INSERT,
		OP_DEQUEUE,
		OP_STATUS
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [ID_IN_W-1:0] id;
	} cmd_t;

endpackage

`default_nettype wire

[hdl/pq_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pq_in_if
	import pq_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [SLOT_W-1:0]  position;
	logic [ID_IN_W-1:0] item_id;

	modport source (output valid, output command, output position, output item_id,
		input ready);
	modport sink (input valid, input command, input position, input item_id,
		output ready);
endinterface

`default_nettype wire

[hdl/pq_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pq_out_if
	import pq_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [ID_IN_W-1:0] item_id_res;
	logic               queue_empty;
	logic               last;

	modport source (output valid, output item_id_res, output queue_empty, output last,
		input ready);
	modport sink (input valid, input item_id_res, input queue_empty, input last,
		output ready);
endinterface

`default_nettype wire

[hdl/positional_insert_queue.sv]
// Append, insert and dequeue take effect at the edge where their item leaves the
// two-entry command queue; one such item per cycle while no status dump is running.
// Status gives one result per stored entry (one when empty) and holds the executor
// while they are taken, since every entry is read at the head cell as the cells rotate.
// First status result is registered at the edge where its item leaves the command queue.
// arst_n clears the count, queue pointers and output valid; cells are not reset.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_queue
	import pq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pq_in_if.sink     req,
	pq_out_if.source  res
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	pq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	pq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res       (res)
	);

endmodule

`default_nettype wire

[hdl/pq_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pq_front
	import pq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pq_in_if.sink     req,
	output logic      cmd_valid,
	output cmd_t      cmd,
	input  wire logic cmd_pop
);

	cmd_t       dec;
	cmd_t       fifo_q [CQ_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	always_comb begin
		dec.id   = req.item_id;
		dec.slot = '0;
		dec.op   = OP_STATUS;
		unique case (req.command)
			CMD_APPEND: begin
				dec.op = OP_APPEND;
			end
			CMD_INSERT: begin
				// Positions are 1-based; zero also means the head.
				dec.op = OP_INSERT;
				if (req.position != '0) begin
					dec.slot = req.position - SLOT_W'(1);
				end
			end
			CMD_DEQUEUE: begin
				dec.op = OP_DEQUEUE;
			end
			CMD_STATUS: begin
				dec.op = OP_STATUS;
			end
		endcase
	end

	assign req.ready = (fill_q != CQ_FULL);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (fill_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && cmd_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CQ_FULL) else $error("command queue overfilled");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> fill_q != '0) else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

[hdl/pq_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pq_back
	import pq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	pq_out_if.source  res
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;

	typedef enum logic {
		ST_EXEC,
		ST_DUMP
	} st_t;

	st_t                state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      remain_q;
	logic               out_valid_q;
	logic [ID_IN_W-1:0] id_res_q;
	logic               empty_q;
	logic               last_q;

	logic [ID_WIDTH-1:0] cell_q [QUEUE_DEPTH];

	logic                       out_free;
	logic                       full;
	logic                       do_add;
	logic                       do_deq;
	logic                       do_rot;
	logic [SW-1:0]              slot_x;
	logic [SW-1:0]              count_x;
	logic [SW-1:0]              clamp_x;
	logic [CW-1:0]              slot_eff;
	logic [ID_WIDTH+ID_IN_W-1:0] id_wide;
	logic [ID_WIDTH-1:0]        id_w;
	logic [ID_WIDTH+ID_IN_W-1:0] head_wide;
	logic [ID_IN_W-1:0]         head_id;

	assign out_free = !out_valid_q || res.ready;
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign cmd_pop  = (state_q == ST_EXEC) && cmd_valid
		&& ((cmd.op != OP_STATUS) || out_free);
	assign do_add   = cmd_pop && ((cmd.op == OP_APPEND) || (cmd.op == OP_INSERT)) && !full;
	assign do_deq   = cmd_pop && (cmd.op == OP_DEQUEUE) && (count_q != '0);
	// A status dump rotates the cells toward the head, one per result, so every
	// entry is read at the head cell and the order is restored at the end.
	assign do_rot   = (count_q != '0) && out_free
		&& ((state_q == ST_DUMP) || (cmd_pop && (cmd.op == OP_STATUS)));

	assign slot_x  = SW'(cmd.slot);
	assign count_x = SW'(count_q);
	assign clamp_x = (slot_x > count_x) ? count_x : slot_x;
	assign slot_eff = (cmd.op == OP_APPEND) ? count_q : CW'(clamp_x);

	assign id_wide   = {{ID_WIDTH{1'b0}}, cmd.id};
	assign id_w      = id_wide[ID_WIDTH-1:0];
	assign head_wide = {{ID_IN_W{1'b0}}, cell_q[0]};
	assign head_id   = head_wide[ID_IN_W-1:0];

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		localparam int PRV = (k + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
		localparam int NXT = (k + 1) % QUEUE_DEPTH;
		logic [ID_WIDTH-1:0] cell_d;

		always_comb begin
			cell_d = cell_q[k];
			if (do_add) begin
				if (CW'(k) == slot_eff) begin
					cell_d = id_w;
				end else if ((CW'(k) > slot_eff) && (CW'(k) <= count_q)) begin
					cell_d = cell_q[PRV];
				end
			end else if (do_deq) begin
				if ((CW'(k) + CW'(1)) < count_q) begin
					cell_d = cell_q[NXT];
				end
			end else if (do_rot) begin
				if ((CW'(k) + CW'(1)) < count_q) begin
					cell_d = cell_q[NXT];
				end else if ((CW'(k) + CW'(1)) == count_q) begin
					cell_d = cell_q[0];
				end
			end
		end

		always_ff @(posedge clk) begin
			cell_q[k] <= cell_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXEC;
			count_q     <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
			id_res_q    <= '0;
			empty_q     <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_add) begin
				count_q <= count_q + CW'(1);
			end else if (do_deq) begin
				count_q <= count_q - CW'(1);
			end
			unique case (state_q)
				ST_EXEC: begin
					if (cmd_pop && (cmd.op == OP_STATUS)) begin
						out_valid_q <= 1'b1;
						if (count_q == '0) begin
							id_res_q <= '0;
							empty_q  <= 1'b1;
							last_q   <= 1'b1;
						end else begin
							id_res_q <= head_id;
							empty_q  <= 1'b0;
							last_q   <= (count_q == CW'(1));
							remain_q <= count_q - CW'(1);
							if (count_q > CW'(1)) begin
								state_q <= ST_DUMP;
							end
						end
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						id_res_q    <= head_id;
						empty_q     <= 1'b0;
						last_q      <= (remain_q == CW'(1));
						remain_q    <= remain_q - CW'(1);
						if (remain_q == CW'(1)) begin
							state_q <= ST_EXEC;
						end
					end
				end
			endcase
		end
	end

	assign res.valid       = out_valid_q;
	assign res.item_id_res = id_res_q;
	assign res.queue_empty = empty_q;
	assign res.last        = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("entry count above depth");
	a_no_pop_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> !cmd_pop) else $error("command taken during dump");
	a_dump_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && (cmd.op == OP_STATUS) && (count_q > CW'(1)))
		|=> ((state_q == ST_DUMP) && (remain_q == $past(count_q) - CW'(1))))
		else $error("status dump did not start correctly");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import pq_pkg::*;

	localparam int DEPTH    = 16;
	localparam int NUM_ROWS = 23;

	typedef struct packed {
		logic [ID_IN_W-1:0] id;
		logic               empty;
		logic               last;
	} dump_res_t;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [SLOT_W-1:0]  pos;
		logic [ID_IN_W-1:0] id;
		int                 reps;
		bit                 typed;
		dump_res_t          res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	pq_in_if  req_if ();
	pq_out_if res_if ();

	positional_insert_queue #(
		.QUEUE_DEPTH(DEPTH),
		.ID_WIDTH   (16)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.res   (res_if)
	);

	// Shadow copy of the queue contents, head at index 0.
	logic [ID_IN_W-1:0] shadow_cells[$];
	dump_res_t          dump_expect[$];

	int send_idle = 36;
	int recv_idle = 80;
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int status_dumps = 0;
	int full_dumps = 0;
	int dropped_adds = 0;
	int empty_dequeues = 0;

	// Directed table. Rows with a typed result are single-result status dumps.
	stim_row_t dir_rows [NUM_ROWS] = '{
		'{CMD_STATUS,  5'd0,  16'h0000, 1,  1'b1, '{16'h0000, 1'b1, 1'b1}},
		'{CMD_DEQUEUE, 5'd0,  16'h0000, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_STATUS,  5'd0,  16'h0000, 1,  1'b1, '{16'h0000, 1'b1, 1'b1}},
		'{CMD_APPEND,  5'd0,  16'hFFFF, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_STATUS,  5'd31, 16'hFFFF, 1,  1'b1, '{16'hFFFF, 1'b0, 1'b1}},
		'{CMD_DEQUEUE, 5'd31, 16'hFFFF, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_STATUS,  5'd0,  16'h0000, 1,  1'b1, '{16'h0000, 1'b1, 1'b1}},
		'{CMD_INSERT,  5'd0,  16'h0000, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_INSERT,  5'd0,  16'h1234, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_INSERT,  5'd31, 16'hABCD, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_INSERT,  5'd2,  16'h5555, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_INSERT,  5'd4,  16'h00FF, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_APPEND,  5'd0,  16'hAAAA, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_STATUS,  5'd0,  16'h0000, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_APPEND,  5'd0,  16'h8000, 10, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_APPEND,  5'd0,  16'h7777, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_INSERT,  5'd1,  16'h6666, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_STATUS,  5'd0,  16'h0000, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_DEQUEUE, 5'd0,  16'h0000, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_INSERT,  5'd16, 16'h0001, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_STATUS,  5'd0,  16'h0000, 1,  1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_DEQUEUE, 5'd0,  16'h0000, 16, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{CMD_STATUS,  5'd0,  16'h0000, 1,  1'b1, '{16'h0000, 1'b1, 1'b1}}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results still expected", dump_expect.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Applies one accepted command to the shadow queue and queues the
	// status results it causes. Returns 0 when the block ignores it.
	function automatic bit apply_queue_cmd(input logic [CMD_W-1:0] cmd,
		input logic [SLOT_W-1:0] pos, input logic [ID_IN_W-1:0] id);
		int        slot;
		bit        effect;
		dump_res_t r;
		effect = 1'b1;
		case (cmd)
			CMD_APPEND, CMD_INSERT: begin
				if (cmd == CMD_APPEND)
					slot = shadow_cells.size();
				else
					slot = (pos == 0) ? 0 : int'(pos) - 1;
				if (shadow_cells.size() >= DEPTH) begin
					effect = 1'b0;
					dropped_adds++;
				end else begin
					if (slot > shadow_cells.size())
						slot = shadow_cells.size();
					shadow_cells.insert(slot, id);
				end
			end
			CMD_DEQUEUE: begin
				if (shadow_cells.size() == 0) begin
					effect = 1'b0;
					empty_dequeues++;
				end else begin
					void'(shadow_cells.pop_front());
				end
			end
			default: begin
				status_dumps++;
				if (shadow_cells.size() == DEPTH)
					full_dumps++;
				if (shadow_cells.size() == 0) begin
					r = '{16'h0000, 1'b1, 1'b1};
					dump_expect.push_back(r);
				end else begin
					for (int k = 0; k < shadow_cells.size(); k++) begin
						r.id    = shadow_cells[k];
						r.empty = 1'b0;
						r.last  = (k == shadow_cells.size() - 1);
						dump_expect.push_back(r);
					end
				end
			end
		endcase
		return effect;
	endfunction

	task automatic drive_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] pos,
		input logic [ID_IN_W-1:0] id, input bit typed, input dump_res_t typed_res,
		output bit effect);
		while ($urandom_range(99) < send_idle) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.command  <= cmd;
		req_if.position <= pos;
		req_if.item_id  <= id;
		do
			@(posedge clk);
		while (!req_if.ready);
		items_sent++;
		if (typed) begin
			dump_expect.push_back(typed_res);
			status_dumps++;
			effect = 1'b1;
		end else begin
			effect = apply_queue_cmd(cmd, pos, id);
		end
	endtask

	// Hold the request side quiet until the block has delivered everything.
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (dump_expect.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Result side: random back-pressure and the scoreboard check.
	always @(posedge clk) begin
		dump_res_t want;
		if (res_if.valid && res_if.ready) begin
			results_seen++;
			if (dump_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: id %h empty %b last %b",
						res_if.item_id_res, res_if.queue_empty, res_if.last);
			end else begin
				want = dump_expect.pop_front();
				if (res_if.item_id_res !== want.id || res_if.queue_empty !== want.empty
					|| res_if.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected id %h empty %b last %b, got id %h empty %b last %b",
							want.id, want.empty, want.last,
							res_if.item_id_res, res_if.queue_empty, res_if.last);
				end
			end
		end
		res_if.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		stim_row_t          row;
		bit                 eff;
		int                 effective;
		int                 pick;
		logic [CMD_W-1:0]   cmd;
		logic [SLOT_W-1:0]  pos;
		logic [ID_IN_W-1:0] id;

		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.command  = CMD_APPEND;
		req_if.position = '0;
		req_if.item_id  = '0;
		res_if.ready    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			for (int k = 0; k < row.reps; k++)
				drive_cmd(row.cmd, row.pos, row.id + ID_IN_W'(k), row.typed, row.res, eff);
		end
		wait_drained();

		// Phase 0 leans toward adds, phase 1 toward dequeues, phase 2 runs with no idle on either side.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle = 36; recv_idle = 80; end
				1: begin send_idle = 80; recv_idle = 36; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			effective = 0;
			while (effective < 21) begin
				pick = $urandom_range(99);
				case (phase)
					0: cmd = (pick < 40) ? CMD_APPEND : (pick < 75) ? CMD_INSERT :
						(pick < 85) ? CMD_DEQUEUE : CMD_STATUS;
					1: cmd = (pick < 15) ? CMD_APPEND : (pick < 30) ? CMD_INSERT :
						(pick < 80) ? CMD_DEQUEUE : CMD_STATUS;
					default: cmd = (pick < 30) ? CMD_APPEND : (pick < 60) ? CMD_INSERT :
						(pick < 85) ? CMD_DEQUEUE : CMD_STATUS;
				endcase
				if ($urandom_range(3) == 0)
					pos = SLOT_W'($urandom_range(31));
				else
					pos = SLOT_W'($urandom_range(shadow_cells.size() + 1));
				id = ID_IN_W'($urandom());
				drive_cmd(cmd, pos, id, 1'b0, '0, eff);
				if (eff)
					effective++;
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (dump_expect.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", dump_expect.size());
		end

		$display("Sent %0d commands, including %0d status dumps (%0d of a full queue); %0d results checked.",
			items_sent, status_dumps, full_dumps, results_seen);
		$display("Adds dropped on a full queue: %0d; dequeues of an empty queue: %0d.",
			dropped_adds, empty_dequeues);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
